### rtl/core/mpq_pkg.sv
// Shared types and constants for the min priority queue.
// Used by mpq_ctrl, mpq_dp and min_priority_queue; depends on nothing.
package mpq_pkg;

   localparam int KEY_W            = 32;
   localparam int ACT_W            = 2;
   localparam int STAT_W           = 2;
   localparam int DEFAULT_CAPACITY = 256;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REPORT = 2'd2;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   localparam logic signed [KEY_W-1:0] EMPTY_KEY = 32'sh7fffffff;

   typedef enum logic [2:0] {
      RD_UP     = 3'd0,
      RD_LAST   = 3'd1,
      RD_ROOT   = 3'd2,
      RD_CHILD  = 3'd3,
      RD_CHILD1 = 3'd4
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_KEY  = 2'd0,
      WR_RD   = 2'd1,
      WR_CAND = 2'd2
   } wr_src_type;

   typedef enum logic [1:0] {
      RES_OK    = 2'd0,
      RES_EMPTY = 2'd1,
      RES_FULL  = 2'd2,
      RES_ROOT  = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic        load_req;
      logic        pos_to_occ;
      logic        pos_to_zero;
      logic        pos_to_up;
      logic        pos_to_cand;
      logic        occ_inc;
      logic        occ_dec;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_src_type  wr_src;
      logic        key_from_rd;
      logic        cand_load_l;
      logic        cand_pick_r;
      logic        res_set;
      res_sel_type res_sel;
      logic        rsp_load;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic pos_zero;
      logic key_lt_rd;
      logic child_ge_occ;
      logic child1_lt_occ;
      logic cand_lt_key;
      logic rsp_busy;
   } stat_type;

endpackage

### rtl/core/mpq_dp.sv
// Datapath: heap key store, occupancy, sift position and result registers.
// Driven by mpq_ctrl through mpq_pkg::cmd_type; depends on mpq_pkg.
module mpq_dp #(
   parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic signed [mpq_pkg::KEY_W-1:0] req_key_in,
   input  mpq_pkg::cmd_type                 cmd,
   output mpq_pkg::stat_type                stat,
   output logic [$clog2(CAPACITY+1)-1:0]    occupancy,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mpq_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [mpq_pkg::KEY_W-1:0] rsp_min_key
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW + 1;

   logic signed [mpq_pkg::KEY_W-1:0] key_store_ff [CAPACITY];
   logic signed [mpq_pkg::KEY_W-1:0] rd_data_ff;

   logic signed [mpq_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [mpq_pkg::KEY_W-1:0] cand_ff, cand_in;
   logic [PW-1:0]                    cand_idx_ff, cand_idx_in;
   logic [PW-1:0]                    pos_ff, pos_in;
   logic [CW-1:0]                    occ_ff, occ_in;
   logic [mpq_pkg::STAT_W-1:0]       res_status_ff, res_status_in;
   logic signed [mpq_pkg::KEY_W-1:0] res_key_ff, res_key_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [mpq_pkg::STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [mpq_pkg::KEY_W-1:0] rsp_min_key_ff, rsp_min_key_in;

   logic [PW-1:0]                    occ_ext, up, child, child1;
   logic [CW-1:0]                    occ_last;
   logic [AW-1:0]                    rd_addr, wr_addr;
   logic signed [mpq_pkg::KEY_W-1:0] wr_data;

   assign occ_ext  = {1'b0, occ_ff};
   assign up       = (pos_ff - PW'(1)) >> 1;
   assign child    = {pos_ff[PW-2:0], 1'b1};
   assign child1   = child + PW'(1);
   assign occ_last = occ_ff - CW'(1);
   assign wr_addr  = pos_ff[AW-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         mpq_pkg::RD_UP:     rd_addr = up[AW-1:0];
         mpq_pkg::RD_LAST:   rd_addr = occ_last[AW-1:0];
         mpq_pkg::RD_CHILD:  rd_addr = child[AW-1:0];
         mpq_pkg::RD_CHILD1: rd_addr = child1[AW-1:0];
         default:            rd_addr = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.wr_src)
         mpq_pkg::WR_RD:   wr_data = rd_data_ff;
         mpq_pkg::WR_CAND: wr_data = cand_ff;
         default:          wr_data = key_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         key_store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= key_store_ff[rd_addr];
      end
   end

   always_comb begin
      key_in         = key_ff;
      cand_in        = cand_ff;
      cand_idx_in    = cand_idx_ff;
      pos_in         = pos_ff;
      occ_in         = occ_ff;
      res_status_in  = res_status_ff;
      res_key_in     = res_key_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_min_key_in = rsp_min_key_ff;

      if (cmd.load_req) begin
         key_in = req_key_in;
      end else if (cmd.key_from_rd) begin
         key_in = rd_data_ff;
      end

      if (cmd.cand_load_l) begin
         cand_in     = rd_data_ff;
         cand_idx_in = child;
      end else if (cmd.cand_pick_r && (rd_data_ff < cand_ff)) begin
         cand_in     = rd_data_ff;
         cand_idx_in = child1;
      end

      priority if (cmd.pos_to_occ) begin
         pos_in = occ_ext;
      end else if (cmd.pos_to_zero) begin
         pos_in = '0;
      end else if (cmd.pos_to_up) begin
         pos_in = up;
      end else if (cmd.pos_to_cand) begin
         pos_in = cand_idx_ff;
      end

      if (cmd.occ_inc) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.occ_dec) begin
         occ_in = occ_last;
      end

      if (cmd.res_set) begin
         unique case (cmd.res_sel)
            mpq_pkg::RES_EMPTY: begin
               res_status_in = mpq_pkg::ST_EMPTY;
               res_key_in    = mpq_pkg::EMPTY_KEY;
            end
            mpq_pkg::RES_FULL: begin
               res_status_in = mpq_pkg::ST_FULL;
               res_key_in    = '0;
            end
            mpq_pkg::RES_ROOT: begin
               res_status_in = mpq_pkg::ST_OK;
               res_key_in    = rd_data_ff;
            end
            default: begin
               res_status_in = mpq_pkg::ST_OK;
               res_key_in    = '0;
            end
         endcase
      end

      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = res_status_ff;
         rsp_min_key_in = res_key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      cand_ff        <= cand_in;
      cand_idx_ff    <= cand_idx_in;
      pos_ff         <= pos_in;
      res_status_ff  <= res_status_in;
      res_key_ff     <= res_key_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_min_key_ff <= rsp_min_key_in;
   end

   assign stat.empty         = (occ_ff == '0);
   assign stat.full          = (occ_ff == CW'(CAPACITY));
   assign stat.pos_zero      = (pos_ff == '0);
   assign stat.key_lt_rd     = (key_ff < rd_data_ff);
   assign stat.child_ge_occ  = (child >= occ_ext);
   assign stat.child1_lt_occ = (child1 < occ_ext);
   assign stat.cand_lt_key   = (cand_ff < key_ff);
   assign stat.rsp_busy      = rsp_valid_ff & ~rsp_ready;

   assign occupancy   = occ_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_min_key = rsp_min_key_ff;

endmodule

### rtl/core/mpq_ctrl.sv
// Controller: sequences insert sift-up, remove sift-down and report.
// Issues mpq_pkg::cmd_type to mpq_dp and reads mpq_pkg::stat_type back.
module mpq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mpq_pkg::ACT_W-1:0]   req_action,
   input  mpq_pkg::stat_type           stat,
   output mpq_pkg::cmd_type            cmd
);

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_PUSH_CHK = 10'b0000000010,
      S_PUSH_CMP = 10'b0000000100,
      S_POP_LAST = 10'b0000001000,
      S_POP_CHK  = 10'b0000010000,
      S_POP_L    = 10'b0000100000,
      S_POP_R    = 10'b0001000000,
      S_POP_CMP  = 10'b0010000000,
      S_REP      = 10'b0100000000,
      S_DONE     = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  mpq_pkg::ACT_INSERT: begin
                     if (stat.full) begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = mpq_pkg::RES_FULL;
                        state_in    = S_DONE;
                     end else begin
                        cmd.load_req   = 1'b1;
                        cmd.pos_to_occ = 1'b1;
                        state_in       = S_PUSH_CHK;
                     end
                  end
                  mpq_pkg::ACT_REMOVE: begin
                     if (stat.empty) begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = mpq_pkg::RES_EMPTY;
                        state_in    = S_DONE;
                     end else begin
                        cmd.occ_dec     = 1'b1;
                        cmd.pos_to_zero = 1'b1;
                        cmd.rd_en       = 1'b1;
                        cmd.rd_sel      = mpq_pkg::RD_LAST;
                        state_in        = S_POP_LAST;
                     end
                  end
                  mpq_pkg::ACT_REPORT: begin
                     if (stat.empty) begin
                        cmd.res_set = 1'b1;
                        cmd.res_sel = mpq_pkg::RES_EMPTY;
                        state_in    = S_DONE;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = mpq_pkg::RD_ROOT;
                        state_in   = S_REP;
                     end
                  end
                  default: begin
                     cmd.res_set = 1'b1;
                     cmd.res_sel = mpq_pkg::RES_OK;
                     state_in    = S_DONE;
                  end
               endcase
            end
         end
         S_PUSH_CHK: begin
            if (stat.pos_zero) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_src  = mpq_pkg::WR_KEY;
               cmd.occ_inc = 1'b1;
               cmd.res_set = 1'b1;
               cmd.res_sel = mpq_pkg::RES_OK;
               state_in    = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mpq_pkg::RD_UP;
               state_in   = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.key_lt_rd) begin
               cmd.wr_src    = mpq_pkg::WR_RD;
               cmd.pos_to_up = 1'b1;
               state_in      = S_PUSH_CHK;
            end else begin
               cmd.wr_src  = mpq_pkg::WR_KEY;
               cmd.occ_inc = 1'b1;
               cmd.res_set = 1'b1;
               cmd.res_sel = mpq_pkg::RES_OK;
               state_in    = S_DONE;
            end
         end
         S_POP_LAST: begin
            cmd.key_from_rd = 1'b1;
            state_in        = S_POP_CHK;
         end
         S_POP_CHK: begin
            if (stat.child_ge_occ) begin
               cmd.wr_en   = ~stat.empty;
               cmd.wr_src  = mpq_pkg::WR_KEY;
               cmd.res_set = 1'b1;
               cmd.res_sel = mpq_pkg::RES_OK;
               state_in    = S_DONE;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mpq_pkg::RD_CHILD;
               state_in   = S_POP_L;
            end
         end
         S_POP_L: begin
            cmd.cand_load_l = 1'b1;
            if (stat.child1_lt_occ) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = mpq_pkg::RD_CHILD1;
               state_in   = S_POP_R;
            end else begin
               state_in = S_POP_CMP;
            end
         end
         S_POP_R: begin
            cmd.cand_pick_r = 1'b1;
            state_in        = S_POP_CMP;
         end
         S_POP_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.cand_lt_key) begin
               cmd.wr_src      = mpq_pkg::WR_CAND;
               cmd.pos_to_cand = 1'b1;
               state_in        = S_POP_CHK;
            end else begin
               cmd.wr_src  = mpq_pkg::WR_KEY;
               cmd.res_set = 1'b1;
               cmd.res_sel = mpq_pkg::RES_OK;
               state_in    = S_DONE;
            end
         end
         S_REP: begin
            cmd.res_set = 1'b1;
            cmd.res_sel = mpq_pkg::RES_ROOT;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/min_priority_queue.sv
// Min priority queue top level: binary min-heap of signed keys.
// Instantiates mpq_ctrl and mpq_dp; depends on mpq_pkg.
//
//   channel | ports                                          | item
//   req     | req_valid, req_ready, req_action, req_key_in   | one operation
//   rsp     | rsp_valid, rsp_ready, rsp_status, rsp_min_key  | one status and key
//
// One item at a time, one memory read port. An insert climbs the key level by
// level until its parent is not larger or it reaches the root; a remove sinks
// the last key level by level until no child is smaller or it reaches a leaf.
// Reset clears occupancy, the response valid flag and control only; the key store is not swept.
// A finished result sits in the output register, so a new item can be
// taken while it waits; the next result waits until rsp_ready frees it.
module min_priority_queue #(
   parameter int CAPACITY = mpq_pkg::DEFAULT_CAPACITY
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mpq_pkg::ACT_W-1:0]        req_action,
   input  logic signed [mpq_pkg::KEY_W-1:0] req_key_in,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mpq_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [mpq_pkg::KEY_W-1:0] rsp_min_key
);

   localparam int CW = $clog2(CAPACITY + 1);

   mpq_pkg::cmd_type  cmd;
   mpq_pkg::stat_type stat;
   logic [CW-1:0]     occupancy;

   mpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd)
   );

   mpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_key_in  (req_key_in),
      .cmd         (cmd),
      .stat        (stat),
      .occupancy   (occupancy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_status  (rsp_status),
      .rsp_min_key (rsp_min_key)
   );

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in work");

   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mpq_pkg::ST_EMPTY) |-> rsp_min_key == mpq_pkg::EMPTY_KEY)
      else $error("empty status without empty key");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == mpq_pkg::ST_OK || rsp_status == mpq_pkg::ST_EMPTY
                     || rsp_status == mpq_pkg::ST_FULL))
      else $error("undefined status code");

endmodule
